// File: hdl/four_voice_wavetable_synth_top_assert.svh
// Assertion macros used by the checker file.
`ifndef FOUR_VOICE_WAVETABLE_SYNTH_TOP_ASSERT_SVH
`define FOUR_VOICE_WAVETABLE_SYNTH_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define FVWS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("fvws: assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define FVWS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("fvws: assertion failed");

`endif

// File: hdl/fvws_pkg.sv
package fvws_pkg;

	// Item kinds carried in tuser
	localparam logic [1:0] OP_TICK     = 2'd0;
	localparam logic [1:0] OP_VOICE_WR = 2'd1;
	localparam logic [1:0] OP_MEM_WR   = 2'd2;

	// Voice register selects
	localparam logic [1:0] REG_VOLUME = 2'd0;
	localparam logic [1:0] REG_STEP   = 2'd1;
	localparam logic [1:0] REG_WSEL   = 2'd2;

	// Stream widths
	localparam int IN_TDATA_W  = 32;
	localparam int OUT_TDATA_W = 40;

	// Output stage constants
	localparam logic [9:0] PWM_IDLE    = 10'd1023;
	localparam logic [7:0] SLEW_MAX    = 8'd63;
	localparam logic [7:0] MID_LEVEL   = 8'd128;
	localparam logic [7:0] SAMPLE_BIAS = 8'h80;

	// Tick sequencer
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FETCH,
		ST_MUL,
		ST_ACC,
		ST_FIN
	} state_t;

endpackage

// File: hdl/four_voice_wavetable_synth_top.sv
// Writes (voice register or waveform byte) complete in the accept cycle, no result.
// A tick runs each voice in turn through one shared 8x9 multiplier (fetch, multiply,
// accumulate), then one slew step loads the registered result.
// Ready returns in the cycle that result becomes valid, so a new tick waits until the
// last one is through; the slew step stretches while an older result waits for tready.
// Reset clears voice state and control, sets level to 128; waveform memory is not cleared.
module four_voice_wavetable_synth_top #(
	parameter int VOICES    = 4,
	parameter int WAVEFORMS = 4
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	// voice[1:0], reg_select[3:2], address[13:4], value[29:14], zero pad
	input  logic [fvws_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
	// op[1:0]
	input  logic [1:0]                       s_axis_tuser,
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	// pwm_up[9:0], pwm_down[19:10], level[27:20], mix[35:28], zero pad
	output logic [fvws_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
	import fvws_pkg::*;

	localparam int VW = (VOICES > 1) ? $clog2(VOICES) : 1;

	// waveform select modulo WAVEFORMS, low two bits form the memory base
	localparam logic [1:0] WSEL_MOD0 = 2'(0 % WAVEFORMS);
	localparam logic [1:0] WSEL_MOD1 = 2'(1 % WAVEFORMS);
	localparam logic [1:0] WSEL_MOD2 = 2'(2 % WAVEFORMS);
	localparam logic [1:0] WSEL_MOD3 = 2'(3 % WAVEFORMS);

	// input fields
	logic [1:0]  in_op;
	logic [1:0]  in_voice;
	logic [1:0]  in_sel;
	logic [9:0]  in_addr;
	logic [15:0] in_value;
	logic        in_fire;
	logic        voice_ok;

	assign in_op    = s_axis_tuser;
	assign in_voice = s_axis_tdata[1:0];
	assign in_sel   = s_axis_tdata[3:2];
	assign in_addr  = s_axis_tdata[13:4];
	assign in_value = s_axis_tdata[29:14];
	assign in_fire  = s_axis_tvalid && s_axis_tready;
	assign voice_ok = (32'(in_voice) < VOICES);

	// state
	state_t state_q, state_d;
	logic   load_out;

	logic [15:0] phase_acc_q  [VOICES];
	logic [15:0] phase_step_q [VOICES];
	logic [7:0]  target_vol_q [VOICES];
	logic [7:0]  cur_vol_q    [VOICES];
	logic [1:0]  wave_sel_q   [VOICES];
	logic [7:0]  wave_mem     [1024];

	logic [VW-1:0]      k_q;
	logic               last_voice;
	logic [7:0]         rd_data_q;
	logic signed [15:0] prod_q;
	logic [7:0]         mix_q;
	logic [7:0]         level_q;

	logic       out_valid_q;
	logic [9:0] pwm_up_q;
	logic [9:0] pwm_down_q;
	logic [7:0] out_level_q;
	logic [7:0] out_mix_q;

	assign last_voice = (k_q == VW'(VOICES - 1));

	// sequencer: state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// sequencer: next state and strobes
	always_comb begin
		state_d       = state_q;
		s_axis_tready = 1'b0;
		load_out      = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_axis_tready = 1'b1;
				if (s_axis_tvalid && in_op == OP_TICK) begin
					state_d = ST_FETCH;
				end
			end
			ST_FETCH: state_d = ST_MUL;
			ST_MUL:   state_d = ST_ACC;
			ST_ACC: begin
				state_d = last_voice ? ST_FIN : ST_FETCH;
			end
			ST_FIN: begin
				if (!out_valid_q || m_axis_tready) begin
					load_out = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// per-voice update for the voice in work
	logic [15:0] phase_next;
	logic [7:0]  vol_next;
	logic [1:0]  wsel_eff;
	logic [9:0]  rd_addr;

	assign phase_next = phase_acc_q[k_q] + phase_step_q[k_q];

	always_comb begin
		vol_next = cur_vol_q[k_q];
		if (cur_vol_q[k_q] < target_vol_q[k_q]) begin
			vol_next = cur_vol_q[k_q] + 8'd1;
		end else if (cur_vol_q[k_q] > target_vol_q[k_q]) begin
			vol_next = cur_vol_q[k_q] - 8'd1;
		end
	end

	always_comb begin
		case (wave_sel_q[k_q])
			2'd0:    wsel_eff = WSEL_MOD0;
			2'd1:    wsel_eff = WSEL_MOD1;
			2'd2:    wsel_eff = WSEL_MOD2;
			2'd3:    wsel_eff = WSEL_MOD3;
			default: wsel_eff = WSEL_MOD0;
		endcase
	end

	assign rd_addr = {wsel_eff, phase_next[15:8]};

	// voice registers: bus writes when idle, phase/volume update in fetch
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int v = 0; v < VOICES; v++) begin
				phase_acc_q[v]  <= '0;
				phase_step_q[v] <= '0;
				target_vol_q[v] <= '0;
				cur_vol_q[v]    <= '0;
				wave_sel_q[v]   <= '0;
			end
		end else begin
			if (in_fire && in_op == OP_VOICE_WR && voice_ok) begin
				case (in_sel)
					REG_VOLUME: target_vol_q[VW'(in_voice)] <= in_value[7:0];
					REG_STEP:   phase_step_q[VW'(in_voice)] <= in_value;
					REG_WSEL:   wave_sel_q[VW'(in_voice)]   <= in_value[1:0];
					default:    ;
				endcase
			end
			if (state_q == ST_FETCH) begin
				phase_acc_q[k_q] <= phase_next;
				cur_vol_q[k_q]   <= vol_next;
			end
		end
	end

	// waveform memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (in_fire && in_op == OP_MEM_WR) begin
			wave_mem[in_addr] <= in_value[7:0];
		end
		if (state_q == ST_FETCH) begin
			rd_data_q <= wave_mem[rd_addr];
		end
	end

	// shared multiplier: (sample - 128) * volume
	always_ff @(posedge clk) begin
		if (state_q == ST_MUL) begin
			prod_q <= $signed(rd_data_q ^ SAMPLE_BIAS) * $signed({1'b0, cur_vol_q[k_q]});
		end
	end

	// voice counter and mix accumulator; prod >>> 8 taken mod 256
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q   <= '0;
			mix_q <= MID_LEVEL;
		end else if (in_fire && in_op == OP_TICK) begin
			k_q   <= '0;
			mix_q <= MID_LEVEL;
		end else if (state_q == ST_ACC) begin
			mix_q <= mix_q + prod_q[15:8];
			k_q   <= last_voice ? '0 : k_q + VW'(1);
		end
	end

	// slew limiter and pin compare values
	logic       rising;
	logic       falling;
	logic [7:0] diff;
	logic [5:0] slew;
	logic [7:0] level_next;
	logic [9:0] pwm_active;

	always_comb begin
		rising     = (mix_q > level_q);
		falling    = (mix_q < level_q);
		diff       = rising ? (mix_q - level_q) : (level_q - mix_q);
		slew       = (diff > SLEW_MAX) ? SLEW_MAX[5:0] : diff[5:0];
		pwm_active = PWM_IDLE - {slew, 4'b0000};
		level_next = level_q;
		if (rising) begin
			level_next = level_q + {2'b00, slew};
		end else if (falling) begin
			level_next = level_q - {2'b00, slew};
		end
	end

	// tracked level and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q     <= MID_LEVEL;
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			level_q     <= level_next;
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			pwm_up_q    <= rising ? pwm_active : PWM_IDLE;
			pwm_down_q  <= falling ? pwm_active : PWM_IDLE;
			out_level_q <= level_next;
			out_mix_q   <= mix_q;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {4'b0000, out_mix_q, out_level_q, pwm_down_q, pwm_up_q};

endmodule

// File: hdl/fvws_checker.sv
`include "four_voice_wavetable_synth_top_assert.svh"

module fvws_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             s_axis_tvalid,
	input logic                             s_axis_tready,
	input logic [fvws_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
	input logic [1:0]                       s_axis_tuser,
	input logic                             m_axis_tvalid,
	input logic                             m_axis_tready,
	input logic [fvws_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
	import fvws_pkg::*;

	logic tick_fire;
	logic wr_fire;
	logic up_idle;
	logic down_idle;

	assign tick_fire = s_axis_tvalid && s_axis_tready && s_axis_tuser == OP_TICK;
	assign wr_fire   = s_axis_tvalid && s_axis_tready && s_axis_tuser != OP_TICK;
	assign up_idle   = (m_axis_tdata[9:0] == PWM_IDLE);
	assign down_idle = (m_axis_tdata[19:10] == PWM_IDLE);

	// a stalled result holds
	`FVWS_ASSERT_NEXT(a_out_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))

	// a tick keeps the block busy while the voices are processed
	`FVWS_ASSERT_NEXT(a_tick_busy, clk, arst_n, tick_fire, !s_axis_tready)

	// writes finish in the accept cycle
	`FVWS_ASSERT_NEXT(a_write_single, clk, arst_n, wr_fire, s_axis_tready)

	// at most one pin is driven
	`FVWS_ASSERT_IMPL(a_one_pin, clk, arst_n, m_axis_tvalid, up_idle || down_idle)

	// both pins idle only when the level already equals the mix
	`FVWS_ASSERT_IMPL(a_idle_level, clk, arst_n, m_axis_tvalid && up_idle && down_idle, m_axis_tdata[27:20] == m_axis_tdata[35:28])

endmodule

bind four_voice_wavetable_synth_top fvws_checker u_fvws_checker (.*);
